@@ design/sclf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol clock loop filter package
// Word widths, reset values, action and register codes, sequencer states and
// the small helper functions shared by the loop filter.
// ----------------------------------------------------------------------------
package sclf_pkg;

  // Q8.24 words, a double word for products and the wrap divisor.
  localparam int WORD_W    = 32;
  localparam int DBL_W     = 2 * WORD_W;
  localparam int GAIN_FRAC = 30;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Half of one Q8.24 step in the Q2.30 x Q8.24 product scale.
  localparam logic signed [DBL_W-1:0] ROUND_HALF = DBL_W'(1) <<< (GAIN_FRAC - 1);

  // Reset values, Q8.24.
  localparam logic [WORD_W-1:0] TWO_Q824    = 32'h0200_0000;
  localparam logic [WORD_W-1:0] MAX_PER_RST = 32'h0400_0000;
  localparam logic [WORD_W-1:0] MIN_PER_RST = 32'h0100_0000;
  localparam logic [WORD_W-1:0] NOM_PER_RST = 32'h0200_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_PER   = 3'd4;

  typedef enum logic [2:0] {
    ACT_ADVANCE   = 3'd0,
    ACT_REVERT    = 3'd1,
    ACT_WRAP      = 3'd2,
    ACT_LIMIT     = 3'd3,
    ACT_LOAD_PH   = 3'd4,
    ACT_LOAD_AVG  = 3'd5,
    ACT_LOAD_INST = 3'd6,
    ACT_RESTART   = 3'd7
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_RND_I,
    ST_SUM_I,
    ST_MUL_P,
    ST_RND_P,
    ST_SUM_P,
    ST_PHASE,
    ST_WR_ABS,
    ST_WR_DIV,
    ST_WR_FIX,
    ST_WR_FOLD,
    ST_WR_SUB,
    ST_LIM_MAX,
    ST_LIM_MIN,
    ST_RS_LO,
    ST_RS_HI,
    ST_RS_MID,
    ST_DONE
  } state_t;

  // Sign-extend a word to a double word.
  function automatic logic signed [DBL_W-1:0] sx(input logic [WORD_W-1:0] v);
    return {{(DBL_W - WORD_W){v[WORD_W-1]}}, v};
  endfunction

  // Saturate a double word to the signed word range.
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [DBL_W-1:0] v);
    logic fits;
    fits = (&v[DBL_W-1:WORD_W-1]) | ~(|v[DBL_W-1:WORD_W-1]);
    if (fits) begin
      return v[WORD_W-1:0];
    end else if (v[DBL_W-1]) begin
      return {1'b1, {(WORD_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W - 1){1'b1}}};
    end
  endfunction

endpackage

@@ design/symbol_clock_loop_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol clock loop filter
// Second-order proportional-plus-integral loop filter of a symbol clock
// tracker in Q8.24, built around one shared 64-bit adder and one multiplier.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers every request with one
// result: average period, instantaneous period and phase after the action.
// All additions and subtractions go through a single 64-bit add/subtract
// unit under a small sequencer, so the request time depends on the action:
// advance runs the accepting cycle, two multiply, round and accumulate
// passes, the phase add and the result load; wrap runs a 32-step
// shift-subtract reduction of the phase by the average period, then the
// fold into half a period. A result waits in the output register until
// taken; the next request is accepted once it has been loaded there.
// Configuration writes are taken in any cycle.
module symbol_clock_loop_filter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sclf_pkg::WORD_W-1:0]       in_tdata,   // [31:0] value
  input  logic [2:0]                        in_tuser,   // [2:0] action
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [3*sclf_pkg::WORD_W-1:0]     out_tdata,  // [31:0] avg_period,
                                                        // [63:32] inst_period,
                                                        // [95:64] clock_phase
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sclf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sclf_pkg::WORD_W-1:0]       cfg_data
);
  import sclf_pkg::*;

  // Configuration registers.
  logic [WORD_W-1:0] prop_gain_r, intg_gain_r, max_per_r, min_per_r, nom_per_r;

  // Loop state and its saved copies.
  logic [WORD_W-1:0] avg_r, avg_nxt, inst_r, inst_nxt, phase_r, phase_nxt;
  logic [WORD_W-1:0] sv_avg_r, sv_avg_nxt, sv_inst_r, sv_inst_nxt;
  logic [WORD_W-1:0] sv_phase_r, sv_phase_nxt;

  // Sequencer and working registers.
  state_t                   state_r, state_nxt;
  logic [WORD_W-1:0]        val_r, val_nxt;
  logic signed [DBL_W-1:0]  prod_r, prod_nxt;
  logic signed [DBL_W-1:0]  work_r, work_nxt;
  logic [DBL_W-1:0]         div_r, div_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     mid_sel_r, mid_sel_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [3*WORD_W-1:0]      out_data_r, out_data_nxt;

  // Shared add/subtract unit.
  logic signed [DBL_W-1:0]  alu_a, alu_b, alu_sum;
  logic                     alu_sub;
  logic signed [WORD_W-1:0] gain_sel;
  logic                     in_req;
  action_t                  act;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_req     = in_tvalid && in_tready;
  assign act        = action_t'(in_tuser);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The one multiplier: integral gain first, proportional gain second.
  assign gain_sel = (state_r == ST_MUL_I) ? intg_gain_r : prop_gain_r;
  assign prod_nxt = gain_sel * $signed(val_r);

  assign alu_sum = alu_a + (alu_b ^ {DBL_W{alu_sub}}) + DBL_W'(alu_sub);

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_RND_I, ST_RND_P: begin
        alu_a = prod_r;
        alu_b = ROUND_HALF;
      end
      ST_SUM_I: begin
        alu_a = sx(avg_r);
        alu_b = work_r;
      end
      ST_SUM_P: begin
        alu_a = sx(avg_r);
        alu_b = work_r;
      end
      ST_PHASE: begin
        alu_a = sx(phase_r);
        alu_b = sx(inst_r);
      end
      ST_WR_ABS: begin
        alu_b   = sx(phase_r);
        alu_sub = phase_r[WORD_W-1];
      end
      ST_WR_DIV: begin
        alu_a   = work_r;
        alu_b   = div_r;
        alu_sub = 1'b1;
      end
      ST_WR_FIX: begin
        alu_a   = sx(avg_r);
        alu_b   = work_r;
        alu_sub = 1'b1;
      end
      ST_WR_FOLD: begin
        alu_a   = sx(avg_r);
        alu_b   = work_r <<< 1;
        alu_sub = 1'b1;
      end
      ST_WR_SUB: begin
        alu_a   = work_r;
        alu_b   = sx(avg_r);
        alu_sub = 1'b1;
      end
      ST_LIM_MAX: begin
        alu_a   = sx(max_per_r);
        alu_b   = sx(avg_r);
        alu_sub = 1'b1;
      end
      ST_LIM_MIN: begin
        alu_a   = sx(avg_r);
        alu_b   = sx(min_per_r);
        alu_sub = 1'b1;
      end
      ST_RS_LO: begin
        alu_a   = sx(nom_per_r);
        alu_b   = sx(min_per_r);
        alu_sub = 1'b1;
      end
      ST_RS_HI: begin
        alu_a   = sx(max_per_r);
        alu_b   = sx(nom_per_r);
        alu_sub = 1'b1;
      end
      ST_RS_MID: begin
        alu_a = sx(max_per_r);
        alu_b = sx(min_per_r);
      end
      default: begin
      end
    endcase
  end

  // Sequencer: next state and next values of the loop state.
  always_comb begin
    logic [WORD_W-1:0] rs_per;
    rs_per        = nom_per_r;
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    inst_nxt      = inst_r;
    phase_nxt     = phase_r;
    sv_avg_nxt    = sv_avg_r;
    sv_inst_nxt   = sv_inst_r;
    sv_phase_nxt  = sv_phase_r;
    val_nxt       = val_r;
    work_nxt      = work_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    mid_sel_nxt   = mid_sel_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          val_nxt = in_tdata;
          unique case (act)
            ACT_ADVANCE: begin
              sv_avg_nxt   = avg_r;
              sv_inst_nxt  = inst_r;
              sv_phase_nxt = phase_r;
              state_nxt    = ST_MUL_I;
            end
            ACT_REVERT: begin
              avg_nxt   = sv_avg_r;
              inst_nxt  = sv_inst_r;
              phase_nxt = sv_phase_r;
              state_nxt = ST_DONE;
            end
            ACT_WRAP:  state_nxt = ST_WR_ABS;
            ACT_LIMIT: state_nxt = ST_LIM_MAX;
            ACT_LOAD_PH: begin
              phase_nxt    = in_tdata;
              sv_phase_nxt = in_tdata;
              state_nxt    = ST_DONE;
            end
            ACT_LOAD_AVG: begin
              avg_nxt    = in_tdata;
              sv_avg_nxt = in_tdata;
              state_nxt  = ST_DONE;
            end
            ACT_LOAD_INST: begin
              inst_nxt    = in_tdata;
              sv_inst_nxt = in_tdata;
              state_nxt   = ST_DONE;
            end
            ACT_RESTART: begin
              mid_sel_nxt = 1'b0;
              state_nxt   = ST_RS_LO;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // Advance: round each gain product to Q8.24, then accumulate.
      ST_MUL_I: state_nxt = ST_RND_I;
      ST_RND_I: begin
        work_nxt  = alu_sum >>> GAIN_FRAC;
        state_nxt = ST_SUM_I;
      end
      ST_SUM_I: begin
        avg_nxt   = sat_word(alu_sum);
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: state_nxt = ST_RND_P;
      ST_RND_P: begin
        work_nxt  = alu_sum >>> GAIN_FRAC;
        state_nxt = ST_SUM_P;
      end
      ST_SUM_P: begin
        inst_nxt  = sat_word(alu_sum);
        state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        phase_nxt = sat_word(alu_sum);
        state_nxt = ST_DONE;
      end

      // Wrap: take the phase magnitude modulo the period by shift-subtract.
      ST_WR_ABS: begin
        if (avg_r[WORD_W-1] || (avg_r == '0)) begin
          state_nxt = ST_DONE;
        end else begin
          work_nxt  = alu_sum;
          div_nxt   = {1'b0, avg_r, {(DBL_W - WORD_W - 1){1'b0}}};
          cnt_nxt   = '0;
          state_nxt = ST_WR_DIV;
        end
      end
      ST_WR_DIV: begin
        if (!alu_sum[DBL_W-1]) begin
          work_nxt = alu_sum;
        end
        div_nxt = div_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_WR_FIX;
        end
      end
      // A negative phase with a nonzero remainder maps to period minus it.
      ST_WR_FIX: begin
        if (phase_r[WORD_W-1] && (work_r != '0)) begin
          work_nxt = alu_sum;
        end
        state_nxt = ST_WR_FOLD;
      end
      // Remainders above half a period move down by one period.
      ST_WR_FOLD: begin
        if (alu_sum[DBL_W-1]) begin
          state_nxt = ST_WR_SUB;
        end else begin
          phase_nxt = work_r[WORD_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_WR_SUB: begin
        phase_nxt = alu_sum[WORD_W-1:0];
        state_nxt = ST_DONE;
      end

      // Limit: the max test wins over the min test.
      ST_LIM_MAX: begin
        if (alu_sum[DBL_W-1]) begin
          avg_nxt   = max_per_r;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LIM_MIN;
        end
      end
      ST_LIM_MIN: begin
        if (alu_sum[DBL_W-1]) begin
          avg_nxt = min_per_r;
        end
        state_nxt = ST_DONE;
      end

      // Restart: nominal period, or the midpoint when it is out of range.
      ST_RS_LO: begin
        if (alu_sum[DBL_W-1]) begin
          mid_sel_nxt = 1'b1;
          state_nxt   = ST_RS_MID;
        end else begin
          state_nxt = ST_RS_HI;
        end
      end
      ST_RS_HI: begin
        mid_sel_nxt = alu_sum[DBL_W-1];
        state_nxt   = ST_RS_MID;
      end
      ST_RS_MID: begin
        if (mid_sel_r) begin
          rs_per = alu_sum[WORD_W:1];
        end
        avg_nxt      = rs_per;
        sv_avg_nxt   = rs_per;
        inst_nxt     = rs_per;
        sv_inst_nxt  = rs_per;
        phase_nxt    = '0;
        sv_phase_nxt = '0;
        state_nxt    = ST_DONE;
      end

      // Load the result once the output register is free.
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {phase_r, inst_r, avg_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and loop state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mid_sel_r   <= 1'b0;
      avg_r       <= TWO_Q824;
      inst_r      <= TWO_Q824;
      phase_r     <= '0;
      sv_avg_r    <= TWO_Q824;
      sv_inst_r   <= TWO_Q824;
      sv_phase_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mid_sel_r   <= mid_sel_nxt;
      avg_r       <= avg_nxt;
      inst_r      <= inst_nxt;
      phase_r     <= phase_nxt;
      sv_avg_r    <= sv_avg_nxt;
      sv_inst_r   <= sv_inst_nxt;
      sv_phase_r  <= sv_phase_nxt;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    prod_r     <= prod_nxt;
    work_r     <= work_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r <= '0;
      intg_gain_r <= '0;
      max_per_r   <= MAX_PER_RST;
      min_per_r   <= MIN_PER_RST;
      nom_per_r   <= NOM_PER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN: prop_gain_r <= cfg_data;
        REG_INTG_GAIN: intg_gain_r <= cfg_data;
        REG_MAX_PER:   max_per_r   <= cfg_data;
        REG_MIN_PER:   min_per_r   <= cfg_data;
        REG_NOM_PER:   nom_per_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sim/symbol_clock_loop_filter_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol clock loop filter testbench
// Drives action requests into the loop filter under bursty input traffic and
// a stalling result side. An internal Q8.24 predictor computes the periods
// and phase after every request, and each result is checked field by field.
// ----------------------------------------------------------------------------
module symbol_clock_loop_filter_top_test;
  import sclf_pkg::*;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct {
    word_t avg;
    word_t inst;
    word_t ph;
  } loop_state_t;

  localparam longint WORD_MAX     = (longint'(1) <<< (WORD_W - 1)) - 1;
  localparam longint WORD_MIN     = -WORD_MAX - 1;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     SETTLE_WAIT  = 64;
  localparam int     PRINT_LIMIT  = 50;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [WORD_W-1:0]    in_tdata   = '0;
  logic [2:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [3*WORD_W-1:0]  out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [WORD_W-1:0]    cfg_data   = '0;

  // Predictor copy of the configuration and loop state.
  word_t gain_alpha, gain_beta, period_max, period_min, period_nom;
  loop_state_t loop_now, loop_saved;

  loop_state_t expected_loop_outputs[$];
  int          mismatch_count = 0;

  // Sender burst control.
  int gap_max    = 0;
  int burst_left = 0;

  // Receiver stall control.
  logic [15:0] rx_pattern    = 16'hA5C3;
  logic        rx_stall_on   = 1'b0;
  int          rx_tick       = 0;
  int          rx_hold_left  = 0;
  bit          rx_hold_start = 1'b0;

  symbol_clock_loop_filter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Saturate a wide intermediate to the signed word range.
  function automatic word_t clamp_word(longint v);
    if (v > WORD_MAX) begin
      return word_t'(WORD_MAX);
    end else if (v < WORD_MIN) begin
      return word_t'(WORD_MIN);
    end
    return word_t'(v);
  endfunction

  // Q2.30 gain times Q8.24 error, rounded to Q8.24 with ties toward +inf.
  function automatic longint gain_product(word_t gain, word_t err);
    longint p;
    p = longint'(gain) * longint'(err) + (longint'(1) <<< (GAIN_FRAC - 1));
    return p >>> GAIN_FRAC;
  endfunction

  // Fold the phase into (-P/2, P/2] with P the average period.
  function automatic void fold_phase();
    longint per, num, den, k;
    per = longint'(loop_now.avg);
    if (per > 0) begin
      num = 2 * longint'(loop_now.ph) - per;
      den = 2 * per;
      if (num >= 0) begin
        k = (num + den - 1) / den;
      end else begin
        k = -((-num) / den);
      end
      loop_now.ph = clamp_word(longint'(loop_now.ph) - k * per);
    end
  endfunction

  // Apply one accepted request to the predictor and queue the outcome.
  function automatic void predict_loop_step(action_t act, word_t val);
    longint p;
    case (act)
      ACT_ADVANCE: begin
        loop_saved   = loop_now;
        loop_now.avg = clamp_word(longint'(loop_now.avg) + gain_product(gain_beta, val));
        loop_now.inst = clamp_word(longint'(loop_now.avg) + gain_product(gain_alpha, val));
        loop_now.ph  = clamp_word(longint'(loop_now.ph) + longint'(loop_now.inst));
      end
      ACT_REVERT: begin
        loop_now = loop_saved;
      end
      ACT_WRAP: begin
        fold_phase();
      end
      ACT_LIMIT: begin
        // The upper bound wins when the bounds are crossed.
        if (loop_now.avg > period_max) begin
          loop_now.avg = period_max;
        end else if (loop_now.avg < period_min) begin
          loop_now.avg = period_min;
        end
      end
      ACT_LOAD_PH: begin
        loop_now.ph   = val;
        loop_saved.ph = val;
      end
      ACT_LOAD_AVG: begin
        loop_now.avg   = val;
        loop_saved.avg = val;
      end
      ACT_LOAD_INST: begin
        loop_now.inst   = val;
        loop_saved.inst = val;
      end
      default: begin
        // Restart at nominal, or at the floor of the bound midpoint when
        // nominal lies outside the bounds.
        p = longint'(period_nom);
        if (p < longint'(period_min) || p > longint'(period_max)) begin
          p = longint'(clamp_word((longint'(period_max) + longint'(period_min)) >>> 1));
        end
        loop_now.avg  = word_t'(p);
        loop_now.inst = word_t'(p);
        loop_now.ph   = '0;
        loop_saved    = loop_now;
      end
    endcase
    expected_loop_outputs.push_back(loop_now);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("ERROR %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Send one request; keeps in_tvalid high inside a burst.
  task automatic send_request(action_t act, word_t val);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    predict_loop_step(act, val);
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering requests and wait for every pending result.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_loop_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN: gain_alpha = data;
      REG_INTG_GAIN: gain_beta  = data;
      REG_MAX_PER:   period_max = data;
      REG_MIN_PER:   period_min = data;
      REG_NOM_PER:   period_nom = data;
      default: ;
    endcase
  endtask

  task automatic set_config(word_t alpha, word_t beta, word_t maxp, word_t minp,
                            word_t nom);
    wait_idle();
    write_reg(REG_PROP_GAIN, alpha);
    write_reg(REG_INTG_GAIN, beta);
    write_reg(REG_MAX_PER, maxp);
    write_reg(REG_MIN_PER, minp);
    write_reg(REG_NOM_PER, nom);
  endtask

  function automatic word_t small_error();
    return word_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
  endfunction

  // Request values: mostly plausible for the action, some noise and extremes.
  function automatic word_t pick_value(action_t act);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return word_t'($urandom);
    end else if (r == 1) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    case (act)
      ACT_LOAD_AVG, ACT_LOAD_INST: return word_t'($urandom_range(32'h0080_0000, 32'h0800_0000));
      ACT_LOAD_PH:                 return small_error() <<< 1;
      default:                     return small_error();
    endcase
  endfunction

  // Tracking traffic: mostly advances, with random wraps, limits, reverts, loads and restarts.
  function automatic action_t pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return ACT_ADVANCE;
    if (r < 70) return ACT_WRAP;
    if (r < 77) return ACT_LIMIT;
    if (r < 83) return ACT_REVERT;
    if (r < 87) return ACT_LOAD_PH;
    if (r < 91) return ACT_LOAD_AVG;
    if (r < 95) return ACT_LOAD_INST;
    if (r < 97) return ACT_RESTART;
    return action_t'($urandom_range(0, 7));
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // State right after reset, seen through a revert of the saved copies.
  task automatic test_reset_state();
    send_request(ACT_REVERT, 32'h1234_5678);
  endtask

  // Gain products exactly halfway between two Q8.24 steps.
  task automatic test_gain_rounding();
    set_config(32'hFFFF_FFFF, 32'h0000_0001, MAX_PER_RST, MIN_PER_RST, NOM_PER_RST);
    send_request(ACT_ADVANCE, 32'h2000_0000);
    send_request(ACT_ADVANCE, 32'hE000_0000);
    send_request(ACT_ADVANCE, 32'h6000_0000);
  endtask

  // Largest gains and errors of both signs drive the period sums into saturation.
  task automatic test_saturation();
    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, MAX_PER_RST, MIN_PER_RST, NOM_PER_RST);
    send_request(ACT_ADVANCE, 32'h7FFF_FFFF);
    send_request(ACT_ADVANCE, 32'h8000_0000);
    set_config(32'h8000_0000, 32'h8000_0000, MAX_PER_RST, MIN_PER_RST, NOM_PER_RST);
    send_request(ACT_ADVANCE, 32'h8000_0000);
  endtask

  // A load updates the saved copy; a second revert restores the same state.
  task automatic test_revert_twice();
    set_config(32'h0400_0000, 32'h0010_0000, MAX_PER_RST, MIN_PER_RST, NOM_PER_RST);
    send_request(ACT_LOAD_INST, 32'h7FFF_FFFF);
    send_request(ACT_ADVANCE, 32'h0080_0000);
    send_request(ACT_REVERT, 32'h0);
    send_request(ACT_REVERT, 32'h0);
  endtask

  // Wrap bounds, a long reduction, and a period that is not positive.
  task automatic test_wrap_bounds();
    send_request(ACT_LOAD_AVG, 32'h0200_0000);
    send_request(ACT_LOAD_PH, 32'h0100_0000);
    send_request(ACT_WRAP, 32'h0);
    send_request(ACT_LOAD_PH, 32'hFF00_0000);
    send_request(ACT_WRAP, 32'h0);
    send_request(ACT_LOAD_AVG, 32'h0000_0001);
    send_request(ACT_LOAD_PH, 32'h8000_0000);
    send_request(ACT_WRAP, 32'h0);
    send_request(ACT_LOAD_AVG, 32'h8000_0000);
    send_request(ACT_WRAP, 32'h0);
  endtask

  // Limit with the minimum above the maximum.
  task automatic test_crossed_limits();
    set_config(32'h0, 32'h0, 32'h0100_0000, 32'h0300_0000, NOM_PER_RST);
    send_request(ACT_LOAD_AVG, 32'h0200_0000);
    send_request(ACT_LIMIT, 32'h0);
    send_request(ACT_LOAD_AVG, 32'h0080_0000);
    send_request(ACT_LIMIT, 32'h0);
    send_request(ACT_REVERT, 32'h0);
  endtask

  // Restart at nominal, and at the midpoint when nominal is out of range.
  task automatic test_restart();
    set_config(32'h0, 32'h0, MAX_PER_RST, MIN_PER_RST, NOM_PER_RST);
    send_request(ACT_RESTART, 32'hFFFF_FFFF);
    set_config(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);
    send_request(ACT_RESTART, 32'h0);
    set_config(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_request(ACT_RESTART, 32'h0);
  endtask

  // Result side holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    int n;
    set_config(32'h0200_0000, 32'h0008_0000, MAX_PER_RST, MIN_PER_RST, NOM_PER_RST);
    gap_max = 0;
    rx_hold_start = 1'b1;
    for (n = 0; n < 24; n++) begin
      send_request(ACT_ADVANCE, small_error());
    end
  endtask

  // Random tracking runs over several configurations, extremes included.
  task automatic test_random_tracking();
    int ph, n;
    word_t minp, maxp, nom;
    action_t act;
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_config(32'h0100_0000, 32'h0004_0000, MAX_PER_RST, MIN_PER_RST, NOM_PER_RST);
        1: set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      word_t'($urandom));
        2: set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        default: begin
          minp = word_t'($urandom_range(32'h0080_0000, 32'h0200_0000));
          maxp = word_t'($urandom_range(32'h0200_0000, 32'h0800_0000));
          nom  = ($urandom_range(0, 3) == 0) ? word_t'($urandom)
                                             : word_t'($urandom_range(minp, maxp));
          if ($urandom_range(0, 3) == 0) begin
            set_config(word_t'($urandom), word_t'($urandom), maxp, minp, nom);
          end else begin
            set_config(word_t'($urandom_range(0, 32'h1000_0000)),
                       word_t'($urandom_range(0, 32'h0100_0000)), maxp, minp, nom);
          end
        end
      endcase
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      send_request(ACT_RESTART, word_t'($urandom));
      for (n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          act = action_t'($urandom_range(0, 7));
          send_request(act, word_t'($urandom));
        end else begin
          act = pick_action();
          send_request(act, pick_value(act));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      rx_stall_on <= 1'b0;
      rx_tick     <= 0;
    end else if (rx_hold_start || rx_hold_left != 0) begin
      if (rx_hold_start) begin
        rx_hold_start = 1'b0;
        rx_hold_left  = HOLD_CYCLES;
      end else begin
        rx_hold_left = rx_hold_left - 1;
      end
      out_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 64 == 63) begin
        rx_pattern  <= 16'($urandom) | 16'h0001;
        rx_stall_on <= ($urandom_range(0, 2) != 0);
      end else begin
        rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
      end
      out_tready <= !rx_stall_on || rx_pattern[0];
    end
  end

  // Compare every result with the oldest pending prediction.
  always @(posedge clk) begin : result_check
    loop_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_loop_outputs.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", out_tdata));
      end else begin
        want = expected_loop_outputs.pop_front();
        if (out_tdata[WORD_W-1:0] !== want.avg) begin
          report_mismatch($sformatf("avg_period expected %h got %h",
                                    want.avg, out_tdata[WORD_W-1:0]));
        end
        if (out_tdata[2*WORD_W-1:WORD_W] !== want.inst) begin
          report_mismatch($sformatf("inst_period expected %h got %h",
                                    want.inst, out_tdata[2*WORD_W-1:WORD_W]));
        end
        if (out_tdata[3*WORD_W-1:2*WORD_W] !== want.ph) begin
          report_mismatch($sformatf("clock_phase expected %h got %h",
                                    want.ph, out_tdata[3*WORD_W-1:2*WORD_W]));
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    gain_alpha = '0;
    gain_beta  = '0;
    period_max = MAX_PER_RST;
    period_min = MIN_PER_RST;
    period_nom = NOM_PER_RST;
    loop_now   = '{avg: TWO_Q824, inst: TWO_Q824, ph: '0};
    loop_saved = loop_now;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_gain_rounding();
    test_saturation();
    test_revert_twice();
    test_wrap_bounds();
    test_crossed_limits();
    test_restart();
    test_output_backpressure();
    test_random_tracking();

    wait_idle();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_loop_outputs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sclf_pkg.sv
design/symbol_clock_loop_filter_top.sv
sim/symbol_clock_loop_filter_top_test.sv
